@@ sv/epf_pkg.sv @@
// Package for the elliptic pursuit follower.
// Holds shared widths, constants and the sequencer state type; no dependencies.
package epf_pkg;

    localparam int unsigned DIV_NUM_W = 65;
    localparam int unsigned DIV_DEN_W = 33;
    localparam int unsigned SQRT_IN_W = 64;
    localparam int unsigned SQRT_OUT_W = 32;

    localparam logic [32:0] AXIS_SCALE = 33'd18350;
    localparam logic [31:0] SAT_U32 = 32'hFFFF_FFFF;
    localparam logic [30:0] SAT_U31 = 31'h7FFF_FFFF;
    localparam logic [32:0] SAT_U33 = 33'h1_FFFF_FFFF;

    localparam logic [1:0] REG_HALF_W = 2'd0;
    localparam logic [1:0] REG_HALF_H = 2'd1;
    localparam logic [1:0] REG_MIN_SPEED = 2'd2;
    localparam logic [1:0] REG_DEAD_ZONE = 2'd3;

    typedef enum logic [33:0] {
        S_IDLE = 34'd1 << 0,
        S_SQX  = 34'd1 << 1,
        S_SQY  = 34'd1 << 2,
        S_RD   = 34'd1 << 3,
        S_WD   = 34'd1 << 4,
        S_AX1  = 34'd1 << 5,
        S_AX2  = 34'd1 << 6,
        S_AX3  = 34'd1 << 7,
        S_AX4  = 34'd1 << 8,
        S_WUX  = 34'd1 << 9,
        S_UY   = 34'd1 << 10,
        S_WUY  = 34'd1 << 11,
        S_EQ1  = 34'd1 << 12,
        S_EQ2  = 34'd1 << 13,
        S_EQ3  = 34'd1 << 14,
        S_WE   = 34'd1 << 15,
        S_TH1  = 34'd1 << 16,
        S_TH2  = 34'd1 << 17,
        S_TH3  = 34'd1 << 18,
        S_TH4  = 34'd1 << 19,
        S_TH5  = 34'd1 << 20,
        S_TH6  = 34'd1 << 21,
        S_SP1  = 34'd1 << 22,
        S_SP2  = 34'd1 << 23,
        S_SP3  = 34'd1 << 24,
        S_SP4  = 34'd1 << 25,
        S_MX1  = 34'd1 << 26,
        S_MX2  = 34'd1 << 27,
        S_WMX  = 34'd1 << 28,
        S_MY1  = 34'd1 << 29,
        S_MY2  = 34'd1 << 30,
        S_WMY  = 34'd1 << 31,
        S_UPD  = 34'd1 << 32,
        S_FIN  = 34'd1 << 33
    } t_state;

endpackage

@@ sv/epf_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on epf_pkg for operand widths.
module epf_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [epf_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [epf_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [epf_pkg::DIV_NUM_W-1:0]  o_quo
);
    import epf_pkg::*;

    logic [DIV_DEN_W-1:0] r_rem, n_rem;
    logic [DIV_NUM_W-1:0] r_quo, n_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [6:0]           r_cnt, n_cnt;
    logic                 r_busy, n_busy, r_done, n_done;
    logic [DIV_DEN_W:0]   rem_sh;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_NUM_W-1]};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_num;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = DIV_DEN_W'(rem_sh - {1'b0, r_den});
                n_quo = {r_quo[DIV_NUM_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DIV_DEN_W-1:0];
                n_quo = {r_quo[DIV_NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'(DIV_NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

@@ sv/epf_sqrt.sv @@
// Integer square root, one result bit per cycle.
// Depends on epf_pkg for operand widths.
module epf_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [epf_pkg::SQRT_IN_W-1:0]   i_rad,
    output logic                            o_done,
    output logic [epf_pkg::SQRT_OUT_W-1:0]  o_root
);
    import epf_pkg::*;

    logic [SQRT_IN_W-1:0]  r_rad, n_rad;
    logic [SQRT_OUT_W+1:0] r_rem, n_rem;
    logic [SQRT_OUT_W-1:0] r_root, n_root;
    logic [5:0]            r_cnt, n_cnt;
    logic                  r_busy, n_busy, r_done, n_done;
    logic [SQRT_OUT_W+3:0] rem_sh;
    logic [SQRT_OUT_W+3:0] trial;

    always_comb begin
        rem_sh = {r_rem, r_rad[SQRT_IN_W-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad = {r_rad[SQRT_IN_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = (SQRT_OUT_W + 2)'(rem_sh - trial);
                n_root = {r_root[SQRT_OUT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh[SQRT_OUT_W+1:0];
                n_root = {r_root[SQRT_OUT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'(SQRT_OUT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ sv/elliptic_pursuit_follower_top.sv @@
// Elliptic pursuit follower: when the follower moves, the result follows two square roots,
// four divisions and the sequencer steps; inside the dead zone the last two divisions are
// skipped, and a zero ellipse axis skips a root and two divisions. One item at a time:
// ready returns as the result appears, or waits while the previous result is held.
// Synchronous active-low reset restores the registers' defaults and zeroes the position.
// Depends on epf_pkg, epf_div and epf_sqrt.
module elliptic_pursuit_follower_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tick_seconds[15:0], goal_x[47:16], goal_y[79:48], goal_speed[111:80],
    // goal_top_speed[143:112]
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // follower_x[31:0], follower_y[63:32], did_move[64], zero pad
    output logic [71:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data
);
    import epf_pkg::*;

    t_state r_state, n_state;

    logic [31:0] r_hsw, r_hsh, r_mins, r_dzf;
    logic signed [31:0] r_px, r_py;
    logic [15:0] r_dt;
    logic [31:0] r_gs, r_gt;
    logic [32:0] r_adx, r_ady;
    logic        r_negx, r_negy, r_big;
    logic [65:0] r_prod;
    logic [63:0] r_sum;
    logic [32:0] r_d;
    logic [30:0] r_axx, r_axy;
    logic [30:0] r_ux, r_uy;
    logic [31:0] r_e;
    logic [48:0] r_p;
    logic [31:0] r_speed;
    logic [31:0] r_step;
    logic [32:0] r_mx, r_my;
    logic        r_move;
    logic        r_ovalid;
    logic [31:0] r_ox, r_oy;
    logic        r_omove;

    logic [32:0] mul_a, mul_b;
    logic [32:0] hx, hy;
    logic        div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den;
    logic        sq_start, sq_done;
    logic [SQRT_IN_W-1:0]  sq_rad;
    logic [SQRT_OUT_W-1:0] sq_root;
    logic signed [32:0] dx_in, dy_in;
    logic signed [31:0] nx, ny;
    logic        accept;

    function automatic logic signed [31:0] sat_move(input logic signed [31:0] base,
                                                    input logic [32:0] amt,
                                                    input logic neg);
        logic signed [34:0] r;
        begin
            r = neg ? (35'(base) - $signed({2'b00, amt}))
                    : (35'(base) + $signed({2'b00, amt}));
            if (r > 35'sh0_7FFF_FFFF) begin
                sat_move = 32'sh7FFF_FFFF;
            end else if (r < -35'sh0_8000_0000) begin
                sat_move = -32'sh8000_0000;
            end else begin
                sat_move = r[31:0];
            end
        end
    endfunction

    function automatic logic [32:0] clamp33(input logic [DIV_NUM_W-1:0] q);
        begin
            clamp33 = (q[DIV_NUM_W-1:33] != '0) ? SAT_U33 : q[32:0];
        end
    endfunction

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign dx_in = $signed({s_axis_tdata[47], s_axis_tdata[47:16]}) - 33'(r_px);
    assign dy_in = $signed({s_axis_tdata[79], s_axis_tdata[79:48]}) - 33'(r_py);
    assign hx = r_big ? {1'b0, r_adx[32:1]} : r_adx;
    assign hy = r_big ? {1'b0, r_ady[32:1]} : r_ady;
    assign nx = sat_move(r_px, r_mx, r_negx);
    assign ny = sat_move(r_py, r_my, r_negy);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQX: begin mul_a = hx; mul_b = hx; end
            S_SQY: begin mul_a = hy; mul_b = hy; end
            S_AX1: begin mul_a = {1'b0, r_hsw}; mul_b = AXIS_SCALE; end
            S_AX2: begin mul_a = {1'b0, r_hsh}; mul_b = AXIS_SCALE; end
            S_EQ1: begin mul_a = {2'b00, r_ux}; mul_b = {2'b00, r_ux}; end
            S_EQ2: begin mul_a = {2'b00, r_uy}; mul_b = {2'b00, r_uy}; end
            S_TH1: begin mul_a = {1'b0, r_dzf}; mul_b = {1'b0, r_gt}; end
            S_TH3: begin mul_a = {1'b0, r_p[31:0]}; mul_b = {17'd0, r_dt}; end
            S_TH4: begin mul_a = {16'd0, r_p[48:32]}; mul_b = {17'd0, r_dt}; end
            S_SP1: begin mul_a = {1'b0, r_gs}; mul_b = {1'b0, r_e}; end
            S_SP3: begin mul_a = {1'b0, r_speed}; mul_b = {17'd0, r_dt}; end
            S_MX1: begin mul_a = {1'b0, r_step}; mul_b = r_adx; end
            S_MY1: begin mul_a = {1'b0, r_step}; mul_b = r_ady; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        sq_start  = 1'b0;
        sq_rad    = '0;
        case (r_state)
            S_RD: begin
                sq_start = 1'b1;
                sq_rad   = r_sum + r_prod[63:0];
            end
            S_EQ3: begin
                sq_start = 1'b1;
                sq_rad   = r_sum + r_prod[63:0];
            end
            S_AX4: begin
                div_start = (r_axx != '0) && (r_axy != '0);
                div_num   = {16'd0, r_adx, 16'd0};
                div_den   = {2'b00, r_axx};
            end
            S_UY: begin
                div_start = 1'b1;
                div_num   = {16'd0, r_ady, 16'd0};
                div_den   = {2'b00, r_axy};
            end
            S_MX2, S_MY2: begin
                div_start = 1'b1;
                div_num   = r_prod[DIV_NUM_W-1:0];
                div_den   = r_d;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_SQX;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_RD;
            S_RD:   n_state = S_WD;
            S_WD:   if (sq_done) n_state = S_AX1;
            S_AX1:  n_state = S_AX2;
            S_AX2:  n_state = S_AX3;
            S_AX3:  n_state = S_AX4;
            S_AX4:  n_state = ((r_axx == '0) || (r_axy == '0)) ? S_TH1 : S_WUX;
            S_WUX:  if (div_done) n_state = S_UY;
            S_UY:   n_state = S_WUY;
            S_WUY:  if (div_done) n_state = S_EQ1;
            S_EQ1:  n_state = S_EQ2;
            S_EQ2:  n_state = S_EQ3;
            S_EQ3:  n_state = S_WE;
            S_WE:   if (sq_done) n_state = S_TH1;
            S_TH1:  n_state = S_TH2;
            S_TH2:  n_state = S_TH3;
            S_TH3:  n_state = S_TH4;
            S_TH4:  n_state = S_TH5;
            S_TH5:  n_state = S_TH6;
            S_TH6:  n_state = ({16'd0, r_d} > 49'((50'(r_p) * 50'd3) >> 1)) ? S_SP1 : S_FIN;
            S_SP1:  n_state = S_SP2;
            S_SP2:  n_state = S_SP3;
            S_SP3:  n_state = S_SP4;
            S_SP4:  n_state = S_MX1;
            S_MX1:  n_state = S_MX2;
            S_MX2:  n_state = S_WMX;
            S_WMX:  if (div_done) n_state = S_MY1;
            S_MY1:  n_state = S_MY2;
            S_MY2:  n_state = S_WMY;
            S_WMY:  if (div_done) n_state = S_UPD;
            S_UPD:  n_state = S_FIN;
            S_FIN:  if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hsw    <= 32'd26214400;
            r_hsh    <= 32'd19660800;
            r_mins   <= 32'd0;
            r_dzf    <= 32'd65536;
            r_px     <= '0;
            r_py     <= '0;
            r_move   <= 1'b0;
            r_ovalid <= 1'b0;
            r_omove  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_HALF_W:    r_hsw  <= i_cfg_data;
                    REG_HALF_H:    r_hsh  <= i_cfg_data;
                    REG_MIN_SPEED: r_mins <= i_cfg_data;
                    REG_DEAD_ZONE: r_dzf  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_TH6) begin
                r_move <= 1'b0;
            end
            if (r_state == S_UPD) begin
                r_px   <= nx;
                r_py   <= ny;
                r_move <= (nx != r_px) || (ny != r_py);
            end
            if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if ((r_state == S_FIN) && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
                r_omove  <= r_move;
            end
        end

        r_prod <= 66'(mul_a) * 66'(mul_b);

        if (accept) begin
            r_dt   <= s_axis_tdata[15:0];
            r_gs   <= s_axis_tdata[111:80];
            r_gt   <= s_axis_tdata[143:112];
            r_negx <= dx_in[32];
            r_negy <= dy_in[32];
            r_adx  <= dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
            r_ady  <= dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
            r_big  <= ((dx_in[32] ? 33'(-dx_in) : 33'(dx_in)) >= 33'h0_8000_0000)
                   || ((dy_in[32] ? 33'(-dy_in) : 33'(dy_in)) >= 33'h0_8000_0000);
        end

        case (r_state)
            S_SQY, S_EQ2: r_sum <= r_prod[63:0];
            S_TH4:        r_sum <= r_prod[63:0];
            default: ;
        endcase
        if ((r_state == S_WD) && sq_done) begin
            r_d <= r_big ? {sq_root, 1'b0} : {1'b0, sq_root};
        end
        if (r_state == S_AX2) r_axx <= r_prod[46:16];
        if (r_state == S_AX3) r_axy <= r_prod[46:16];
        if ((r_state == S_AX4) && ((r_axx == '0) || (r_axy == '0))) r_e <= SAT_U32;
        if ((r_state == S_WUX) && div_done) begin
            r_ux <= (div_quo[DIV_NUM_W-1:31] != '0) ? SAT_U31 : div_quo[30:0];
        end
        if ((r_state == S_WUY) && div_done) begin
            r_uy <= (div_quo[DIV_NUM_W-1:31] != '0) ? SAT_U31 : div_quo[30:0];
        end
        if ((r_state == S_WE) && sq_done) r_e <= sq_root;
        if (r_state == S_TH2) r_p <= {1'b0, r_prod[63:16]};
        if (r_state == S_TH5) begin
            r_p <= 49'(({r_prod[31:0], 32'd0} + r_sum) >> 16);
        end
        if (r_state == S_SP2) begin
            if ((r_prod[63:16] < {16'd0, r_mins})) begin
                r_speed <= r_mins;
            end else if (r_prod[63:48] != '0) begin
                r_speed <= SAT_U32;
            end else begin
                r_speed <= r_prod[47:16];
            end
        end
        if (r_state == S_SP4) r_step <= r_prod[47:16];
        if ((r_state == S_WMX) && div_done) r_mx <= clamp33(div_quo);
        if ((r_state == S_WMY) && div_done) r_my <= clamp33(div_quo);
        if ((r_state == S_FIN) && (!r_ovalid || m_axis_tready)) begin
            r_ox <= r_px;
            r_oy <= r_py;
        end
    end

    epf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    epf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_omove, r_oy, r_ox};

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("sequencer state not one-hot");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SQX)) else $error("item accepted but sequencer idle");

    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_move == ((r_px != $past(r_px)) || (r_py != $past(r_py)))))
        else $error("move flag disagrees with position");

    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && !r_ovalid) |=> m_axis_tvalid)
        else $error("finished item not presented");
endmodule
